// ----- sv/ccc_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar clock counter package
// Shared types, codes and calendar helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

  // Field widths of the calendar counters.
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  // Calendar limits.
  localparam logic [YearW-1:0]   YearMax    = YearW'(16383);
  localparam logic [YearW-1:0]   YearSetMin = YearW'(1970);
  localparam logic [YearW-1:0]   YearSetMax = YearW'(9999);
  localparam logic [YearW-1:0]   YearReset  = YearW'(2026);
  localparam logic [MonthW-1:0]  MonthCnt   = MonthW'(12);
  localparam logic [HourW-1:0]   HourCnt    = HourW'(24);
  localparam logic [MinuteW-1:0] MinuteCnt  = MinuteW'(60);
  localparam logic [SecondW-1:0] SecondCnt  = SecondW'(60);

  // Divisibility by 25 on a 14-bit value: multiply by the inverse of 25
  // modulo 2^14; the product is small exactly for multiples of 25.
  localparam logic [YearW-1:0] Inv25    = YearW'(7209);
  localparam logic [YearW-1:0] Mult25Lim = YearW'(655);

  // Request codes.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } ccc_op_e;

  // Month numbers that carry a length other than 31 days.
  localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonNov = MonthW'(11);

  // Date and time held by the counters.
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } ccc_time_t;

  // One incoming request.
  typedef struct packed {
    ccc_op_e   op;
    ccc_time_t value;
  } ccc_req_t;

  // Gregorian leap year test.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = YearW'(y * Inv25);
    div25 = (prod <= Mult25Lim);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Number of days in a month; codes outside 1..12 count as 31 days.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic              leap);
    logic [DayW-1:0] d;
    case (m) inside
      MonFeb:                         d = leap ? DayW'(29) : DayW'(28);
      MonApr, MonJun, MonSep, MonNov: d = DayW'(30);
      default:                        d = DayW'(31);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ccc_step.sv -----
// ----------------------------------------------------------------------------
// Calendar clock step logic
// Computes the counter state after one request: a one-second cascade or a
// checked load of a new date and time.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_step (
  input  ccc_pkg::ccc_time_t cur_i,
  input  ccc_pkg::ccc_req_t  req_i,
  output ccc_pkg::ccc_time_t nxt_o,
  output logic               rejected_o
);

  ccc_pkg::ccc_time_t tick;
  logic               set_ok;
  logic               sec_wrap;
  logic               min_wrap;
  logic               hour_wrap;
  logic               day_wrap;
  logic               mon_wrap;
  logic [ccc_pkg::SecondW-1:0] sec_inc;
  logic [ccc_pkg::MinuteW-1:0] min_inc;
  logic [ccc_pkg::HourW-1:0]   hour_inc;
  logic [ccc_pkg::DayW:0]      day_inc;
  logic [ccc_pkg::MonthW-1:0]  mon_inc;
  logic [ccc_pkg::DayW-1:0]    mdays;

  // Carry cascade for a one-second tick.
  always_comb begin
    sec_inc   = cur_i.second + 1'b1;
    min_inc   = cur_i.minute + 1'b1;
    hour_inc  = cur_i.hour + 1'b1;
    day_inc   = {1'b0, cur_i.day} + 1'b1;
    mon_inc   = cur_i.month + 1'b1;
    mdays     = ccc_pkg::month_days(cur_i.month, ccc_pkg::is_leap(cur_i.year));

    sec_wrap  = (sec_inc >= ccc_pkg::SecondCnt);
    min_wrap  = sec_wrap && (min_inc >= ccc_pkg::MinuteCnt);
    hour_wrap = min_wrap && (hour_inc >= ccc_pkg::HourCnt);
    day_wrap  = hour_wrap && (day_inc > {1'b0, mdays});
    mon_wrap  = day_wrap && (mon_inc > ccc_pkg::MonthCnt);

    tick        = cur_i;
    tick.second = sec_wrap ? '0 : sec_inc;
    if (sec_wrap) begin
      tick.minute = min_wrap ? '0 : min_inc;
    end
    if (min_wrap) begin
      tick.hour = hour_wrap ? '0 : hour_inc;
    end
    if (hour_wrap) begin
      tick.day = day_wrap ? ccc_pkg::DayW'(1) : day_inc[ccc_pkg::DayW-1:0];
    end
    if (day_wrap) begin
      tick.month = mon_wrap ? ccc_pkg::MonthW'(1) : mon_inc;
    end
    if (mon_wrap && (cur_i.year != ccc_pkg::YearMax)) begin
      tick.year = cur_i.year + 1'b1;
    end
  end

  // Range check of a set request; the day is not checked against the month.
  always_comb begin
    set_ok = (req_i.value.year >= ccc_pkg::YearSetMin) &&
             (req_i.value.year <= ccc_pkg::YearSetMax) &&
             (req_i.value.month != '0) &&
             (req_i.value.month <= ccc_pkg::MonthCnt) &&
             (req_i.value.day != '0) &&
             (req_i.value.hour < ccc_pkg::HourCnt) &&
             (req_i.value.minute < ccc_pkg::MinuteCnt) &&
             (req_i.value.second < ccc_pkg::SecondCnt);
  end

  // Select the outcome of the request.
  always_comb begin
    rejected_o = 1'b0;
    if (req_i.op == ccc_pkg::OP_TICK) begin
      nxt_o = tick;
    end else if (set_ok) begin
      nxt_o = req_i.value;
    end else begin
      nxt_o      = cur_i;
      rejected_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/calendar_clock_counter_unit.sv -----
// ----------------------------------------------------------------------------
// Calendar clock counter unit
// Gregorian date and time counter driven by one-second ticks and set
// requests, with a registered input stage and a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one request: op_i
//   selects a one-second tick or a set of the date and time from the new_*
//   fields. Each request yields exactly one result on the output channel
//   (out_valid_o / out_stall_i): the date and time after the request, and
//   set_rejected_o when a set request was out of range and ignored.
//   out_valid_o rises once an accepted request reaches the result
//   register. One request is accepted every cycle while the receiver takes
//   results; the whole update is one pass through the step logic between
//   the input register and the state and result registers.
//   When the receiver stalls, the result holds; one more request is taken
//   into the input register, after which in_stall_o rises until the
//   result is taken.
//   Reset sets the clock to 2026-01-01 00:00:00 and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [13:0] new_year_i,
  input  logic [3:0]  new_month_i,
  input  logic [4:0]  new_day_i,
  input  logic [4:0]  new_hour_i,
  input  logic [5:0]  new_minute_i,
  input  logic [5:0]  new_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  sec_o,
  output logic        set_rejected_o
);

  logic               req_valid_q;
  ccc_pkg::ccc_req_t  req_q;
  ccc_pkg::ccc_req_t  req_d;
  ccc_pkg::ccc_time_t state_q;
  ccc_pkg::ccc_time_t state_d;
  logic               rej_d;
  logic               out_valid_q;
  ccc_pkg::ccc_time_t res_q;
  logic               res_rej_q;
  logic               res_free;
  logic               in_accept;
  logic               req_fire;

  // Handshake control.
  assign res_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !res_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign req_fire   = req_valid_q && res_free;

  // Pack the incoming request.
  always_comb begin
    req_d.op           = ccc_pkg::ccc_op_e'(op_i);
    req_d.value.year   = new_year_i;
    req_d.value.month  = new_month_i;
    req_d.value.day    = new_day_i;
    req_d.value.hour   = new_hour_i;
    req_d.value.minute = new_minute_i;
    req_d.value.second = new_second_i;
  end

  // Next counter state for the request in the input register.
  ccc_step u_step (
    .cur_i      (state_q),
    .req_i      (req_q),
    .nxt_o      (state_d),
    .rejected_o (rej_d)
  );

  // Control and counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      state_q.year   <= ccc_pkg::YearReset;
      state_q.month  <= ccc_pkg::MonthW'(1);
      state_q.day    <= ccc_pkg::DayW'(1);
      state_q.hour   <= '0;
      state_q.minute <= '0;
      state_q.second <= '0;
    end else begin
      if (!in_stall_o) begin
        req_valid_q <= in_valid_i;
      end
      if (res_free) begin
        out_valid_q <= req_valid_q;
      end
      if (req_fire) begin
        state_q <= state_d;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_d;
    end
    if (req_fire) begin
      res_q     <= state_d;
      res_rej_q <= rej_d;
    end
  end

  // Result outputs.
  assign out_valid_o    = out_valid_q;
  assign year_o         = res_q.year;
  assign month_o        = res_q.month;
  assign day_o          = res_q.day;
  assign hour_o         = res_q.hour;
  assign minute_o       = res_q.minute;
  assign sec_o          = res_q.second;
  assign set_rejected_o = res_rej_q;

endmodule

`default_nettype wire
